// ===== hdl/otf_pkg.sv =====
// Shared types and constants for the Otsu threshold finder.
package otf_pkg;

    localparam int NUM_BINS = 256;
    localparam int BIN_W    = 8;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_READ,
        OP_ACC,
        OP_MUL_TN,
        OP_P1_MUL_NS,
        OP_DIFF,
        OP_MUL_DD,
        OP_NUM_MUL_DEN,
        OP_DEN,
        OP_MUL_LHS,
        OP_LHS_MUL_RHS,
        OP_TAKE,
        OP_NEXT_BIN,
        OP_FINISH
    } t_op;

    // Status flags reported by the datapath.
    typedef struct packed {
        logic mul_busy;
        logic skip;
        logic diff_zero;
        logic first;
        logic better;
        logic last_bin;
        logic out_busy;
    } t_dp_status;

endpackage

// ===== hdl/otf_if.sv =====
// Pixel and result stream interfaces of the Otsu threshold finder.
interface otf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       last_pixel;

    modport source (output valid, output pixel, output last_pixel, input ready);
    modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface otf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] threshold;
    logic       found;

    modport source (output valid, output threshold, output found, input ready);
    modport sink   (input valid, input threshold, input found, output ready);
endinterface

// ===== hdl/otf_mul.sv =====
// Shift-add multiplier shared by all score computations, one multiplier bit per cycle.
module otf_mul #(
    parameter int A_W = 142,
    parameter int B_W = 50
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_busy,
    output logic [A_W-1:0] o_product
);

    logic           r_busy;
    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [A_W-1:0] r_acc;

    // Control: busy until every set bit of the multiplier has been consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_b == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // Datapath: add the shifted multiplicand for each set multiplier bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_busy    = r_busy;
    assign o_product = r_acc;

endmodule

// ===== hdl/otf_datapath.sv =====
// Histogram memory, frame totals, sweep accumulators and score registers.
module otf_datapath
    import otf_pkg::*;
#(
    parameter int COUNT_BITS = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_op              i_op,
    input  logic             i_accept,
    input  logic [BIN_W-1:0] i_pixel,
    input  logic             i_out_ready,
    output t_dp_status       o_status,
    output logic             o_out_valid,
    output logic [BIN_W-1:0] o_threshold,
    output logic             o_found
);

    localparam int CB = COUNT_BITS;
    localparam int VB = COUNT_BITS + BIN_W;
    localparam int DW = 2 * COUNT_BITS + BIN_W;
    localparam int NW = 2 * DW;
    localparam int EW = 2 * COUNT_BITS;
    localparam int PW = NW + EW;

    // Histogram storage with one valid bit per bin.
    logic [CB-1:0]       r_hist [NUM_BINS];
    logic [NUM_BINS-1:0] r_hv;
    logic [CB-1:0]       r_rdata;
    logic                r_rvalid;
    logic [BIN_W-1:0]    rd_addr;

    // Pixel update stage and write forwarding.
    logic             r_s1_valid;
    logic [BIN_W-1:0] r_s1_addr;
    logic             r_fw_valid;
    logic [BIN_W-1:0] r_fw_addr;
    logic [CB-1:0]    r_fw_data;
    logic [CB-1:0]    old_cnt;
    logic [CB-1:0]    new_cnt;

    // Frame totals and sweep state.
    logic [CB-1:0]    r_tot_n;
    logic [VB-1:0]    r_tot_v;
    logic [CB-1:0]    r_n;
    logic [VB-1:0]    r_s;
    logic [BIN_W-1:0] r_bin;
    logic [CB-1:0]    sweep_cnt;

    // Score registers.
    logic [DW-1:0]    r_p1;
    logic [DW-1:0]    r_diff;
    logic [NW-1:0]    r_num;
    logic [EW-1:0]    r_den;
    logic [NW-1:0]    r_best_num;
    logic [EW-1:0]    r_best_den;
    logic [PW-1:0]    r_lhs;
    logic             r_found;
    logic [BIN_W-1:0] r_thr;

    // Output register.
    logic             r_ovalid;
    logic [BIN_W-1:0] r_othr;
    logic             r_ofound;

    // Multiplier operands.
    logic          mul_start;
    logic [PW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic          mul_busy;
    logic [PW-1:0] mul_p;
    logic [DW-1:0] prod_d;

    assign rd_addr = (i_op == OP_READ) ? r_bin : i_pixel;

    // Histogram read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        r_rdata  <= r_hist[rd_addr];
        r_rvalid <= r_hv[rd_addr];
    end

    // Count of the bin in the update stage, taking an in-flight write into account.
    always_comb begin
        if (r_fw_valid && (r_fw_addr == r_s1_addr)) begin
            old_cnt = r_fw_data;
        end else if (r_rvalid) begin
            old_cnt = r_rdata;
        end else begin
            old_cnt = '0;
        end
        new_cnt = old_cnt + CB'(1);
    end

    // Histogram write port.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_hist[r_s1_addr] <= new_cnt;
        end
        r_fw_addr <= r_s1_addr;
        r_fw_data <= new_cnt;
    end

    // Bin valid bits: set on write, all cleared at the end of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_op == OP_FINISH)) begin
            r_hv <= '0;
        end else if (r_s1_valid) begin
            r_hv[r_s1_addr] <= 1'b1;
        end
    end

    // Pixel intake: totals saturate so that the statistics stay consistent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
            r_tot_n    <= '0;
            r_tot_v    <= '0;
        end else begin
            r_fw_valid <= r_s1_valid;
            r_s1_valid <= 1'b0;
            if (i_op == OP_FINISH) begin
                r_tot_n <= '0;
                r_tot_v <= '0;
            end else if (i_accept && (r_tot_n != '1)) begin
                r_s1_valid <= 1'b1;
                r_tot_n    <= r_tot_n + CB'(1);
                r_tot_v    <= r_tot_v + VB'(i_pixel);
            end
        end
        r_s1_addr <= i_pixel;
    end

    assign sweep_cnt = r_rvalid ? r_rdata : '0;
    assign prod_d    = mul_p[DW-1:0];

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_start = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        case (i_op)
            OP_MUL_TN: begin
                mul_a = PW'(r_tot_v);
                mul_b = DW'(r_n);
            end
            OP_P1_MUL_NS: begin
                mul_a = PW'(r_tot_n);
                mul_b = DW'(r_s);
            end
            OP_MUL_DD: begin
                mul_a = PW'(r_diff);
                mul_b = r_diff;
            end
            OP_NUM_MUL_DEN: begin
                mul_a = PW'(r_n);
                mul_b = DW'(r_tot_n - r_n);
            end
            OP_MUL_LHS: begin
                mul_a = PW'(r_num);
                mul_b = DW'(r_best_den);
            end
            OP_LHS_MUL_RHS: begin
                mul_a = PW'(r_best_num);
                mul_b = DW'(r_den);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    otf_mul #(
        .A_W (PW),
        .B_W (DW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_busy    (mul_busy),
        .o_product (mul_p)
    );

    // Sweep control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= '0;
            r_s     <= '0;
            r_bin   <= '0;
            r_found <= 1'b0;
        end else begin
            case (i_op)
                OP_ACC: begin
                    r_n <= r_n + sweep_cnt;
                    r_s <= r_s + VB'(VB'(r_bin) * VB'(sweep_cnt));
                end
                OP_TAKE: begin
                    r_found <= 1'b1;
                end
                OP_NEXT_BIN: begin
                    r_bin <= r_bin + BIN_W'(1);
                end
                OP_FINISH: begin
                    r_n     <= '0;
                    r_s     <= '0;
                    r_bin   <= '0;
                    r_found <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Score registers.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_P1_MUL_NS:   r_p1   <= prod_d;
            OP_DIFF:        r_diff <= (r_p1 >= prod_d) ? (r_p1 - prod_d) : (prod_d - r_p1);
            OP_NUM_MUL_DEN: r_num  <= mul_p[NW-1:0];
            OP_DEN:         r_den  <= mul_p[EW-1:0];
            OP_LHS_MUL_RHS: r_lhs  <= mul_p;
            OP_TAKE: begin
                r_best_num <= r_num;
                r_best_den <= r_den;
                r_thr      <= r_bin;
            end
            default: begin
            end
        endcase
    end

    // Result register, held until the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_op == OP_FINISH) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_op == OP_FINISH) begin
            r_othr   <= r_found ? r_thr : '0;
            r_ofound <= r_found;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.mul_busy  = mul_busy;
        o_status.skip      = (r_n == '0) || (r_n >= r_tot_n);
        o_status.diff_zero = (r_diff == '0);
        o_status.first     = !r_found;
        o_status.better    = (r_lhs > mul_p);
        o_status.last_bin  = (r_bin == BIN_W'(NUM_BINS - 1));
        o_status.out_busy  = r_ovalid && !i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_threshold = r_othr;
    assign o_found     = r_ofound;

endmodule

// ===== hdl/otf_ctrl.sv =====
// Controller that sequences the pixel phase and the per-bin score sweep.
module otf_ctrl
    import otf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept_last,
    input  t_dp_status i_status,
    output t_op        o_op,
    output logic       o_idle
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FLUSH,
        S_READ,
        S_ACC,
        S_CHK,
        S_W1,
        S_W2,
        S_DZ,
        S_W3,
        S_W4,
        S_CMP,
        S_W5,
        S_W6,
        S_NEXT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE:  if (i_accept_last) n_state = S_FLUSH;
            S_FLUSH: n_state = S_READ;
            S_READ: begin
                o_op    = OP_READ;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_op    = OP_ACC;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_status.skip) begin
                    n_state = S_NEXT;
                end else begin
                    o_op    = OP_MUL_TN;
                    n_state = S_W1;
                end
            end
            S_W1: begin
                if (!i_status.mul_busy) begin
                    o_op    = OP_P1_MUL_NS;
                    n_state = S_W2;
                end
            end
            S_W2: begin
                if (!i_status.mul_busy) begin
                    o_op    = OP_DIFF;
                    n_state = S_DZ;
                end
            end
            S_DZ: begin
                if (i_status.diff_zero) begin
                    n_state = S_NEXT;
                end else begin
                    o_op    = OP_MUL_DD;
                    n_state = S_W3;
                end
            end
            S_W3: begin
                if (!i_status.mul_busy) begin
                    o_op    = OP_NUM_MUL_DEN;
                    n_state = S_W4;
                end
            end
            S_W4: begin
                if (!i_status.mul_busy) begin
                    o_op    = OP_DEN;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_status.first) begin
                    o_op    = OP_TAKE;
                    n_state = S_NEXT;
                end else begin
                    o_op    = OP_MUL_LHS;
                    n_state = S_W5;
                end
            end
            S_W5: begin
                if (!i_status.mul_busy) begin
                    o_op    = OP_LHS_MUL_RHS;
                    n_state = S_W6;
                end
            end
            S_W6: begin
                if (!i_status.mul_busy) begin
                    if (i_status.better) begin
                        o_op = OP_TAKE;
                    end
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_status.last_bin) begin
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_NEXT_BIN;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_op    = OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ===== hdl/otsu_threshold_finder_unit.sv =====
// Otsu threshold finder: takes one pixel per clock while a frame streams in, builds a
// 256-bin histogram with pixel count and value sum, and after the item flagged last
// sweeps the bins to find the threshold of greatest between-class variance. Scores are
// compared exactly in integers. During the frame one pixel item is accepted every clock.
// After the last pixel the input is held off for the sweep: a flush state, then per bin
// control states and up to six products on the shared shift-add multiplier, each holding
// the sweep until every set bit of its multiplier operand (at most 2*COUNT_BITS+8
// significant bits) is consumed; the sweep also waits for the previous result to be taken.
// Histogram bins carry valid bits, so no clearing pass is needed after reset or between
// frames. Once 2^COUNT_BITS-1 pixels are counted, further pixels of the frame are ignored.
// A frame with no positive score reports threshold 0 with found low.
module otsu_threshold_finder_unit
    import otf_pkg::*;
#(
    parameter int COUNT_BITS = 21
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    otf_pix_if.sink   i_pix,
    otf_res_if.source o_res
);

    t_op        op;
    t_dp_status status;
    logic       idle;
    logic       accept;

    assign i_pix.ready = idle;
    assign accept      = i_pix.valid && idle;

    // Sequencing of the pixel phase and the sweep.
    otf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept_last (accept && i_pix.last_pixel),
        .i_status      (status),
        .o_op          (op),
        .o_idle        (idle)
    );

    // Histogram, statistics and score arithmetic.
    otf_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_accept    (accept),
        .i_pixel     (i_pix.pixel),
        .i_out_ready (o_res.ready),
        .o_status    (status),
        .o_out_valid (o_res.valid),
        .o_threshold (o_res.threshold),
        .o_found     (o_res.found)
    );

    // A frame without a winning bin reports threshold zero.
    a_zero_when_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.found || (o_res.threshold == '0)))
        else $error("threshold nonzero without a found bin");

    // The end of a frame stops intake until the sweep is done.
    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && i_pix.last_pixel) |=> !i_pix.ready)
        else $error("pixel intake open right after the last pixel");

    // Nothing is offered right after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result offered right after reset");

endmodule
